/* hdl/grid_dfs_path_finder_assert.svh */
// assertion macros shared by the grid path finder modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef GRID_DFS_PATH_FINDER_ASSERT_SVH
`define GRID_DFS_PATH_FINDER_ASSERT_SVH

// checked only outside reset
`define GDPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define GDPF_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

/* hdl/gdpf_pkg.sv */
// shared constants, types and helpers of the grid path finder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gdpf_pkg;

    // grid geometry and result limit
    localparam int GRID_ROWS   = 5;
    localparam int GRID_COLS   = 5;
    localparam int NUM_CELLS   = GRID_ROWS * GRID_COLS;
    localparam int MAX_RESULTS = 24;

    // field widths
    localparam int ROW_W  = 3;
    localparam int COL_W  = 3;
    localparam int KIND_W = 2;
    localparam int LIM_W  = ROW_W + 1;

    // storage widths
    localparam int CELL_W  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int DEPTH_W = $clog2(NUM_CELLS + 1);
    localparam int LEFT_W  = $clog2(MAX_RESULTS);
    localparam int MOVE_W  = 3;

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    // cell kinds
    localparam logic [KIND_W-1:0] KIND_FREE     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OBSTACLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GOAL     = 2'd2;

    // move order: up, down, left, right, then exhausted
    localparam logic [1:0]        DIR_UP    = 2'd0;
    localparam logic [1:0]        DIR_DOWN  = 2'd1;
    localparam logic [1:0]        DIR_LEFT  = 2'd2;
    localparam logic [1:0]        DIR_RIGHT = 2'd3;
    localparam logic [MOVE_W-1:0] MOVE_DONE = 3'd4;

    // one stack entry: cell and next move to try
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [MOVE_W-1:0] move;
    } t_stk_ent;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic emit_single;
        logic single_found;
        logic emit_goal;
        logic emit_entry;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic start_ok;
        logic start_goal;
        logic goal_hit;
        logic exhausted;
        logic out_free;
        logic left_zero;
        logic left_one;
    } t_dp_status;

    // flat cell address, row major
    function automatic logic [CELL_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return CELL_W'(int'(row) * GRID_COLS + int'(col));
    endfunction

endpackage

`default_nettype wire

/* hdl/grid_dfs_path_finder.sv */
// channel   direction  handshake                 payload
// in        to block   i_in_valid / o_in_ready   i_op, i_cell_row/col/kind, i_start_row/col
// out       from block o_out_valid / i_out_ready o_found, o_has_cell, o_path_row/col, o_last
//
// a load beat is accepted while idle; the grid write lands at the accepting edge
// a valid solve with the start off the goal initializes the search, then takes one step per
// neighbor probe or stack pop (at most five per cell), then emits the result beats in turn
// the single-probe search loop (one grid and visited read per cycle) sets solve time
// a stalled output holds the result register and pauses emission; no new beat is
// taken until the last result of a solve is in the result register
// synchronous active-low reset clears the grid to free, the visited marks and the controller
`timescale 1ns / 1ps
`default_nettype none

module grid_dfs_path_finder import gdpf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_op,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [COL_W-1:0]  i_cell_col,
    input  logic [KIND_W-1:0] i_cell_kind,
    input  logic [ROW_W-1:0]  i_start_row,
    input  logic [COL_W-1:0]  i_start_col,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_found,
    output logic              o_has_cell,
    output logic [ROW_W-1:0]  o_path_row,
    output logic [COL_W-1:0]  o_path_col,
    output logic              o_last
);

    t_dp_cmd    cmd;
    t_dp_status st;

    // sequencer
    gdpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    // storage and result register
    gdpf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_cell_row  (i_cell_row),
        .i_cell_col  (i_cell_col),
        .i_cell_kind (i_cell_kind),
        .i_start_row (i_start_row),
        .i_start_col (i_start_col),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_has_cell  (o_has_cell),
        .o_path_row  (o_path_row),
        .o_path_col  (o_path_col),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

/* hdl/gdpf_dp.sv */
// datapath of the grid path finder: grid, visited marks, search stack, result register
// depends on gdpf_pkg and grid_dfs_path_finder_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "grid_dfs_path_finder_assert.svh"

module gdpf_dp import gdpf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_st,
    input  logic [ROW_W-1:0]  i_cell_row,
    input  logic [COL_W-1:0]  i_cell_col,
    input  logic [KIND_W-1:0] i_cell_kind,
    input  logic [ROW_W-1:0]  i_start_row,
    input  logic [COL_W-1:0]  i_start_col,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_found,
    output logic              o_has_cell,
    output logic [ROW_W-1:0]  o_path_row,
    output logic [COL_W-1:0]  o_path_col,
    output logic              o_last
);

    logic [KIND_W-1:0]  r_grid [NUM_CELLS];
    logic [NUM_CELLS-1:0] r_visited;
    t_stk_ent           r_stack [NUM_CELLS];
    t_stk_ent           r_top;
    logic [DEPTH_W-1:0] r_depth;
    logic [CELL_W-1:0]  r_idx;
    logic [LEFT_W-1:0]  r_left;
    logic [ROW_W-1:0]   r_goal_row;
    logic [COL_W-1:0]   r_goal_col;
    logic               r_out_valid;
    logic               r_found;
    logic               r_has_cell;
    logic [ROW_W-1:0]   r_path_row;
    logic [COL_W-1:0]   r_path_col;
    logic               r_last;

    logic               load_ok;
    logic               start_ok;
    logic [CELL_W-1:0]  load_idx;
    logic [CELL_W-1:0]  start_idx;
    logic               nbr_ok;
    logic [ROW_W-1:0]   nbr_row;
    logic [COL_W-1:0]   nbr_col;
    logic [CELL_W-1:0]  nbr_idx;
    logic [CELL_W-1:0]  rd_idx;
    logic [KIND_W-1:0]  rd_kind;
    logic               rd_vis;
    logic               top_done;
    logic               open;
    logic               goal_hit;
    logic               can_push;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic [CELL_W-1:0]  stk_rd_addr;
    t_stk_ent           stk_rd;
    logic               out_free;

    // address and kind checks on the incoming beat
    assign load_ok  = ({1'b0, i_cell_row} < LIM_W'(GRID_ROWS))
                   && ({1'b0, i_cell_col} < LIM_W'(GRID_COLS))
                   && (i_cell_kind == KIND_FREE || i_cell_kind == KIND_OBSTACLE
                       || i_cell_kind == KIND_GOAL);
    assign start_ok = ({1'b0, i_start_row} < LIM_W'(GRID_ROWS))
                   && ({1'b0, i_start_col} < LIM_W'(GRID_COLS));
    assign load_idx  = cell_index(i_cell_row, i_cell_col);
    assign start_idx = cell_index(i_start_row, i_start_col);

    // neighbor of the top cell for its current move
    always_comb begin
        nbr_ok  = 1'b0;
        nbr_row = r_top.row;
        nbr_col = r_top.col;
        unique case (r_top.move[1:0])
            DIR_UP: begin
                nbr_ok  = (r_top.row != '0);
                nbr_row = r_top.row - ROW_W'(1);
            end
            DIR_DOWN: begin
                nbr_ok  = ({1'b0, r_top.row} < LIM_W'(GRID_ROWS - 1));
                nbr_row = r_top.row + ROW_W'(1);
            end
            DIR_LEFT: begin
                nbr_ok  = (r_top.col != '0);
                nbr_col = r_top.col - COL_W'(1);
            end
            DIR_RIGHT: begin
                nbr_ok  = ({1'b0, r_top.col} < LIM_W'(GRID_COLS - 1));
                nbr_col = r_top.col + COL_W'(1);
            end
            default: nbr_ok = 1'b0;
        endcase
    end

    assign nbr_idx = cell_index(nbr_row, nbr_col);

    // single grid / visited read port: neighbor while searching, start cell otherwise
    assign rd_idx  = i_cmd.step ? nbr_idx : start_idx;
    assign rd_kind = (int'(rd_idx) < NUM_CELLS) ? r_grid[rd_idx] : KIND_FREE;
    assign rd_vis  = (int'(rd_idx) < NUM_CELLS) ? r_visited[rd_idx] : 1'b1;

    // step outcome
    assign top_done = (r_top.move == MOVE_DONE);
    assign open     = !top_done && nbr_ok && (rd_kind != KIND_OBSTACLE) && !rd_vis;
    assign goal_hit = i_cmd.step && open && (rd_kind == KIND_GOAL);
    assign can_push = open && (rd_kind != KIND_GOAL) && (int'(r_depth) < NUM_CELLS);
    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign depth_m2 = r_depth - DEPTH_W'(2);

    // stack read: entry below the top on a pop, path entry while emitting
    assign stk_rd_addr = i_cmd.step ? depth_m2[CELL_W-1:0] : r_idx;
    assign stk_rd      = (int'(stk_rd_addr) < NUM_CELLS) ? r_stack[stk_rd_addr] : r_top;

    assign out_free = !r_out_valid || i_out_ready;

    // status back to the controller
    always_comb begin
        o_st.start_ok   = start_ok;
        o_st.start_goal = start_ok && (rd_kind == KIND_GOAL);
        o_st.goal_hit   = goal_hit;
        o_st.exhausted  = top_done && (r_depth == DEPTH_W'(1));
        o_st.out_free   = out_free;
        o_st.left_zero  = (r_left == '0);
        o_st.left_one   = (r_left == LEFT_W'(1));
    end

    // grid cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CELLS; i++) begin
                r_grid[i] <= KIND_FREE;
            end
        end else if (i_cmd.load && load_ok) begin
            r_grid[load_idx] <= i_cell_kind;
        end
    end

    // visited marks, cleared in one go at solve start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_visited <= '0;
        end else if (i_cmd.init) begin
            r_visited <= NUM_CELLS'(1) << start_idx;
        end else if (i_cmd.step && can_push) begin
            r_visited[nbr_idx] <= 1'b1;
        end
    end

    // stack depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_cmd.init) begin
            r_depth <= DEPTH_W'(1);
        end else if (i_cmd.step) begin
            if (top_done) begin
                r_depth <= depth_m1;
            end else if (can_push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end
        end
    end

    // top entry cache, stack body, path walk pointers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_top <= '{row: i_start_row, col: i_start_col, move: '0};
        end
        if (i_cmd.step) begin
            if (top_done) begin
                if (r_depth != DEPTH_W'(1)) begin
                    r_top <= stk_rd;
                end
            end else if (goal_hit) begin
                // park the top so the whole path reads from the stack
                r_stack[depth_m1[CELL_W-1:0]] <= r_top;
                r_idx      <= depth_m1[CELL_W-1:0];
                r_goal_row <= nbr_row;
                r_goal_col <= nbr_col;
                if (int'(r_depth) > MAX_RESULTS) begin
                    r_left <= LEFT_W'(MAX_RESULTS - 1);
                end else begin
                    r_left <= LEFT_W'(depth_m1);
                end
            end else if (can_push) begin
                r_stack[depth_m1[CELL_W-1:0]] <= '{row: r_top.row, col: r_top.col,
                                                   move: r_top.move + MOVE_W'(1)};
                r_top <= '{row: nbr_row, col: nbr_col, move: '0};
            end else begin
                r_top.move <= r_top.move + MOVE_W'(1);
            end
        end
        if (i_cmd.emit_entry) begin
            r_idx  <= r_idx - CELL_W'(1);
            r_left <= r_left - LEFT_W'(1);
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_single || i_cmd.emit_goal || i_cmd.emit_entry) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_single) begin
            r_found    <= i_cmd.single_found;
            r_has_cell <= 1'b0;
            r_path_row <= '0;
            r_path_col <= '0;
            r_last     <= 1'b1;
        end else if (i_cmd.emit_goal) begin
            r_found    <= 1'b1;
            r_has_cell <= 1'b1;
            r_path_row <= r_goal_row;
            r_path_col <= r_goal_col;
            r_last     <= (r_left == '0);
        end else if (i_cmd.emit_entry) begin
            r_found    <= 1'b1;
            r_has_cell <= 1'b1;
            r_path_row <= stk_rd.row;
            r_path_col <= stk_rd.col;
            r_last     <= (r_left == LEFT_W'(1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_has_cell  = r_has_cell;
    assign o_path_row  = r_path_row;
    assign o_path_col  = r_path_col;
    assign o_last      = r_last;

    // checks
    `GDPF_ASSERT(a_depth_bound, int'(r_depth) <= NUM_CELLS, "stack depth beyond grid size")
    `GDPF_ASSERT(a_step_nonempty, i_cmd.step |-> (r_depth != '0), "search step on empty stack")
    `GDPF_ASSERT(a_emit_slot, (i_cmd.emit_single || i_cmd.emit_goal || i_cmd.emit_entry) |-> (!r_out_valid || i_out_ready), "result beat overwritten")

endmodule

`default_nettype wire

/* hdl/gdpf_ctrl.sv */
// controller of the grid path finder: sequences load, search and result beats
// depends on gdpf_pkg and grid_dfs_path_finder_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "grid_dfs_path_finder_assert.svh"

module gdpf_ctrl import gdpf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_op,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_NOPATH,
        S_ATGOAL,
        S_GOAL,
        S_PATH
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else if (!i_st.start_ok) begin
                        n_state = S_NOPATH;
                    end else if (i_st.start_goal) begin
                        n_state = S_ATGOAL;
                    end else begin
                        o_cmd.init = 1'b1;
                        n_state    = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_st.goal_hit) begin
                    n_state = S_GOAL;
                end else if (i_st.exhausted) begin
                    n_state = S_NOPATH;
                end
            end
            S_NOPATH: begin
                if (i_st.out_free) begin
                    o_cmd.emit_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_ATGOAL: begin
                if (i_st.out_free) begin
                    o_cmd.emit_single  = 1'b1;
                    o_cmd.single_found = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_GOAL: begin
                if (i_st.out_free) begin
                    o_cmd.emit_goal = 1'b1;
                    n_state         = i_st.left_zero ? S_IDLE : S_PATH;
                end
            end
            S_PATH: begin
                if (i_st.out_free) begin
                    o_cmd.emit_entry = 1'b1;
                    if (i_st.left_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // checks
    `GDPF_ASSERT(a_cmd_onehot, $onehot0({o_cmd.load, o_cmd.init, o_cmd.step, o_cmd.emit_single, o_cmd.emit_goal, o_cmd.emit_entry}), "more than one datapath command")
    `GDPF_ASSERT(a_goal_to_emit, (r_state == S_SEARCH && i_st.goal_hit) |=> (r_state == S_GOAL), "goal hit not followed by goal beat")
    `GDPF_ASSERT(a_path_end, (r_state == S_PATH && o_cmd.emit_entry && i_st.left_one) |=> (r_state == S_IDLE), "path walk did not end on last beat")
    `GDPF_ASSERT_NR(a_reset_idle, (!i_rst_n) |=> (r_state == S_IDLE), "controller not idle after reset")

endmodule

`default_nettype wire
